>>> rtl/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// types, codes and helpers shared by the page table walker modules
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_XLATE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_MAPPED = 2'd0,
        ST_ABSENT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_DIR  = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    typedef struct packed {
        op_t         op;
        logic [11:0] word_index;
        logic [63:0] word_data;
        logic [39:0] root_frame;
        logic [47:0] va;
    } cmd_t;

    function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] lvl);
        logic [8:0] idx;
        begin
            case (lvl)
                LVL_TOP:  idx = va[47:39];
                LVL_PDPT: idx = va[38:30];
                LVL_DIR:  idx = va[29:21];
                LVL_LEAF: idx = va[20:12];
                default:  idx = va[20:12];
            endcase
            return idx;
        end
    endfunction

endpackage

>>> rtl/ptw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_front
// accepts input items, drops writes beyond the store and queues commands
// ----------------------------------------------------------------------------
module ptw_front #(
    parameter int STORE_WORDS = 4096
) (
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [191:0]   s_axis_tdata,
    input  logic           s_axis_tuser,
    input  logic           q_full,
    output logic           q_push,
    output ptw_pkg::cmd_t  q_cmd
);
    import ptw_pkg::*;

    logic        wr_in_range;
    logic [31:0] widx_ext;

    always_comb
    begin
        q_cmd.op         = op_t'(s_axis_tuser);
        q_cmd.word_index = s_axis_tdata[11:0];
        q_cmd.word_data  = s_axis_tdata[75:12];
        q_cmd.root_frame = s_axis_tdata[127:88];
        q_cmd.va         = s_axis_tdata[187:140];
    end

    assign widx_ext      = 32'(s_axis_tdata[11:0]);
    assign wr_in_range   = (widx_ext < 32'(STORE_WORDS));
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full
                           && ((q_cmd.op == OP_XLATE) || wr_in_range);

endmodule

>>> rtl/ptw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_fifo
// short command queue between the front and the walk engine
// ----------------------------------------------------------------------------
module ptw_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptw_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ptw_pkg::cmd_t  head_cmd
);
    import ptw_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/ptw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_back
// table store and walk engine, one dependent store read per level
// ----------------------------------------------------------------------------
module ptw_back #(
    parameter int STORE_WORDS = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  ptw_pkg::cmd_t  cmd,
    output logic           cmd_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [63:0]    m_axis_tdata,
    output logic [2:0]     m_axis_tuser
);
    import ptw_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    lvl_reg, lvl_next;
    logic [47:0]   va_reg, va_next;
    logic [63:0]   rdata_reg;
    logic [63:0]   store [STORE_WORDS];

    logic          out_valid_reg, out_valid_next;
    logic [63:0]   phys_reg, phys_next;
    status_t       status_reg, status_next;
    logic          large_reg, large_next;

    logic          out_free;
    logic          mem_we, mem_re;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   widx_ext;
    logic [48:0]   w_first, w_walk;
    logic          first_ok, walk_ok;
    logic [63:0]   entry;
    logic [1:0]    lvl_inc;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign widx_ext = 32'(cmd.word_index);
    assign wr_addr  = widx_ext[AW-1:0];
    assign entry    = rdata_reg;
    assign lvl_inc  = 2'(lvl_reg + 2'd1);
    assign w_first  = {cmd.root_frame, level_index(cmd.va, LVL_TOP)};
    assign w_walk   = {entry[51:12], level_index(va_reg, lvl_inc)};
    assign first_ok = (w_first < 49'(STORE_WORDS));
    assign walk_ok  = (w_walk < 49'(STORE_WORDS));

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        va_next        = va_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        rd_addr        = w_first[AW-1:0];
        out_valid_next = out_valid_reg && !m_axis_tready;
        phys_next      = phys_reg;
        status_next    = status_reg;
        large_next     = large_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_WRITE)
                    begin
                        mem_we  = 1'b1;
                        cmd_pop = 1'b1;
                    end
                    else if (first_ok)
                    begin
                        mem_re     = 1'b1;
                        cmd_pop    = 1'b1;
                        va_next    = cmd.va;
                        lvl_next   = LVL_TOP;
                        state_next = S_WALK;
                    end
                    else if (out_free)
                    begin
                        cmd_pop        = 1'b1;
                        out_valid_next = 1'b1;
                        phys_next      = '0;
                        status_next    = ST_RANGE;
                        large_next     = 1'b0;
                    end
                end
            end
            S_WALK:
            begin
                rd_addr = w_walk[AW-1:0];
                if (!entry[BIT_PRESENT])
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        phys_next      = '0;
                        status_next    = ST_ABSENT;
                        large_next     = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
                else if ((lvl_reg == LVL_DIR) && entry[BIT_LARGE])
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        phys_next      = {12'd0, entry[51:21], va_reg[20:0]};
                        status_next    = ST_MAPPED;
                        large_next     = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (lvl_reg == LVL_LEAF)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        phys_next      = {12'd0, entry[51:12], va_reg[11:0]};
                        status_next    = ST_MAPPED;
                        large_next     = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
                else if (!walk_ok)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        phys_next      = '0;
                        status_next    = ST_RANGE;
                        large_next     = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mem_re   = 1'b1;
                    lvl_next = lvl_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= LVL_TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg     <= va_next;
        phys_reg   <= phys_next;
        status_reg <= status_next;
        large_reg  <= large_next;
    end

    // table store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[wr_addr] <= cmd.word_data;
        end
        if (mem_re)
        begin
            rdata_reg <= store[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = phys_reg;
    assign m_axis_tuser  = {large_reg, status_reg};

endmodule

>>> rtl/page_table_walk_translate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_walk_translate_top
// four-level page table walker over an internal table store
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_axis    in         write items (table word) and translate items
//  m_axis    out        one result item per translate item
//
//  an accepted item, but for a write beyond the store (dropped at the input), passes
//  through the command queue before the walk engine; a write item gives no result
//  a translate item is popped by the walk engine with the read of the top-level entry
//  (or a fault for a top-level table outside the store), then each level is checked in
//  turn, set by the dependent reads of the single store read port
//  the store is not cleared at reset; a two-entry command queue and the
//  output register let the input side run ahead while a result waits
// ----------------------------------------------------------------------------
module page_table_walk_translate_top #(
    parameter int STORE_WORDS = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // word_index[11:0], word_data[75:12], root_frame[127:88], virtual_addr[187:140]
    input  logic [191:0] s_axis_tdata,
    // operation
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // phys_addr[63:0]
    output logic [63:0]  m_axis_tdata,
    // status[1:0], large_page[2]
    output logic [2:0]   m_axis_tuser
);
    import ptw_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic head_pop;

    ptw_front #(
        .STORE_WORDS (STORE_WORDS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    ptw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ptw_back #(
        .STORE_WORDS (STORE_WORDS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (head_valid),
        .cmd           (head_cmd),
        .cmd_pop       (head_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
